FILE: hdl/tmse_pkg.sv
// Shared types and codes of the Turing machine step engine.
// Holds the request and result field types, operation and verdict codes, and the rule layout.
// Has no dependencies; the engine top level imports it.
package tmse_pkg;

   // Default storage depths.
   localparam int TAPE_DEPTH_DEFAULT = 1024;
   localparam int RULE_DEPTH_DEFAULT = 1024;

   // Width of the reported head position.
   localparam int HEAD_POS_W = 10;

   typedef logic [6:0] mstate_type;
   typedef logic [7:0] symbol_type;
   typedef logic [1:0] move_type;
   typedef logic [1:0] opcode_type;
   typedef logic [1:0] verdict_type;
   typedef logic [1:0] csr_index_type;

   // Request operations.
   localparam opcode_type OP_APPEND_RULE = 2'd0;
   localparam opcode_type OP_APPEND_TAPE = 2'd1;
   localparam opcode_type OP_STEP        = 2'd2;

   // Verdict codes.
   localparam verdict_type VERDICT_RUNNING  = 2'd0;
   localparam verdict_type VERDICT_ACCEPTED = 2'd1;
   localparam verdict_type VERDICT_REJECTED = 2'd2;
   localparam verdict_type VERDICT_FULL     = 2'd3;

   // Head moves as two's complement codes; any other code, zero or minus two, means stay.
   localparam move_type MOVE_LEFT  = 2'b11;
   localparam move_type MOVE_RIGHT = 2'b01;

   // Configuration register indexes.
   localparam csr_index_type CSR_START_STATE  = 2'd0;
   localparam csr_index_type CSR_ACCEPT_STATE = 2'd1;
   localparam csr_index_type CSR_REJECT_STATE = 2'd2;

   // One rule table entry, most significant field first.
   typedef struct packed {
      move_type   move;
      symbol_type write_symbol;
      mstate_type target_state;
      symbol_type read_symbol;
      mstate_type from_state;
   } rule_type;

endpackage

FILE: hdl/turing_machine_step_engine.sv
// Single-tape Turing machine engine with rule table and tape memories.
// Depends on tmse_pkg for field types, codes and the rule entry layout.
//
// Usage:
//   A request is taken at a rising edge where start is high and busy is low.
//   req_operation selects append rule, append tape symbol (req_new_tape restarts
//   the run on a fresh tape) or execute one step. Every request yields exactly one
//   result, shown for one cycle with rsp_strobe high; the receiver cannot stall.
//   Configuration writes (csr_write_enable, csr_index, csr_write_data) take effect
//   at the edge they are seen and are meant for idle periods.
// Timing and throughput:
//   Loads and status requests strobe their result in the cycle after the request
//   and busy stays low, so one such request can be taken every cycle.
//   A step reads the tape at the head, then scans the rule memory one entry a cycle
//   in load order with busy high, and strobes its result once a rule matches or
//   every loaded rule was checked. The single rule memory read port bounds the scan.
//   A step that ends at once (halted run, empty tape, head off the tape, no rules)
//   strobes its result in the cycle after the request, like a load.
// Reset:
//   Synchronous reset empties the rule table and tape, clears state, head and
//   verdict, and loads the default configuration. Memories are not cleared.
module turing_machine_step_engine #(
   parameter int TAPE_DEPTH = tmse_pkg::TAPE_DEPTH_DEFAULT,
   parameter int RULE_DEPTH = tmse_pkg::RULE_DEPTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // Request channel.
   input  logic                                   start,
   output logic                                   busy,
   input  tmse_pkg::opcode_type                   req_operation,
   input  tmse_pkg::mstate_type                   req_rule_from_state,
   input  tmse_pkg::symbol_type                   req_rule_read_symbol,
   input  tmse_pkg::mstate_type                   req_rule_next_state,
   input  tmse_pkg::symbol_type                   req_rule_write_symbol,
   input  logic signed [1:0]                      req_rule_move,
   input  tmse_pkg::symbol_type                   req_tape_symbol,
   input  logic                                   req_new_tape,
   // Result channel.
   output logic                                   rsp_strobe,
   output tmse_pkg::verdict_type                  rsp_verdict,
   output tmse_pkg::mstate_type                   rsp_machine_state,
   output logic [tmse_pkg::HEAD_POS_W-1:0]        rsp_head_position,
   // Configuration port.
   input  logic                                   csr_write_enable,
   input  tmse_pkg::csr_index_type                csr_index,
   input  tmse_pkg::mstate_type                   csr_write_data
);
   import tmse_pkg::*;

   localparam int TAPE_AW = $clog2(TAPE_DEPTH);
   localparam int TAPE_CW = $clog2(TAPE_DEPTH + 1);
   localparam int RULE_AW = (RULE_DEPTH > 1) ? $clog2(RULE_DEPTH) : 1;
   localparam int RULE_CW = $clog2(RULE_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } fsm_type;

   // Control and architectural state.
   fsm_type              fsm_ff, fsm_in;
   logic [RULE_CW-1:0]   rule_count_ff, rule_count_in;
   logic [TAPE_CW-1:0]   tape_length_ff, tape_length_in;
   mstate_type           mstate_ff, mstate_in;
   logic [TAPE_AW-1:0]   head_ff, head_in;
   verdict_type          verdict_ff, verdict_in;
   logic [RULE_CW-1:0]   scan_idx_ff, scan_idx_in;
   logic                 scan_pend_ff, scan_pend_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   logic                 rsp_full_ff, rsp_full_in;

   // Configuration registers.
   mstate_type           start_state_ff;
   mstate_type           accept_state_ff;
   mstate_type           reject_state_ff;

   // Memories and their registered read data.
   rule_type             rule_mem [RULE_DEPTH];
   symbol_type           tape_mem [TAPE_DEPTH];
   rule_type             rule_rd_ff;
   symbol_type           tape_rd_ff;

   // Memory port controls.
   logic                 rule_we;
   logic [RULE_AW-1:0]   rule_waddr;
   rule_type             rule_wdata;
   logic                 rule_re;
   logic [RULE_AW-1:0]   rule_raddr;
   logic                 tape_we;
   logic [TAPE_AW-1:0]   tape_waddr;
   symbol_type           tape_wdata;

   // Helpers.
   logic                 accept_req;
   logic [TAPE_CW-1:0]   head_ext;
   logic [TAPE_CW-1:0]   len_base;
   logic [TAPE_CW-1:0]   new_head;
   logic                 left_off;
   logic                 rule_hit;
   logic [31:0]          head_wide;

   assign accept_req = start && (fsm_ff == ST_IDLE);
   assign head_ext   = TAPE_CW'(head_ff);
   assign len_base   = req_new_tape ? '0 : tape_length_ff;

   // The registered rule entry matches the current state and the registered symbol under the head.
   assign rule_hit = scan_pend_ff && (rule_rd_ff.from_state == mstate_ff) &&
                     (rule_rd_ff.read_symbol == tape_rd_ff);

   // Head move of the matched rule.
   always_comb begin
      new_head = head_ext;
      left_off = 1'b0;
      if (rule_rd_ff.move == MOVE_LEFT) begin
         if (head_ff == '0) begin
            left_off = 1'b1;
         end else begin
            new_head = head_ext - 1'b1;
         end
      end else if (rule_rd_ff.move == MOVE_RIGHT) begin
         new_head = head_ext + 1'b1;
      end
   end

   // Main sequencer: loads, step setup and the rule scan.
   always_comb begin
      fsm_in         = fsm_ff;
      rule_count_in  = rule_count_ff;
      tape_length_in = tape_length_ff;
      mstate_in      = mstate_ff;
      head_in        = head_ff;
      verdict_in     = verdict_ff;
      scan_idx_in    = scan_idx_ff;
      scan_pend_in   = scan_pend_ff;
      rsp_strobe_in  = 1'b0;
      rsp_full_in    = 1'b0;
      rule_we        = 1'b0;
      rule_waddr     = rule_count_ff[RULE_AW-1:0];
      rule_wdata     = '{move:         $unsigned(req_rule_move),
                         write_symbol: req_rule_write_symbol,
                         target_state: req_rule_next_state,
                         read_symbol:  req_rule_read_symbol,
                         from_state:   req_rule_from_state};
      rule_re        = 1'b0;
      rule_raddr     = scan_idx_ff[RULE_AW-1:0];
      tape_we        = 1'b0;
      tape_waddr     = len_base[TAPE_AW-1:0];
      tape_wdata     = req_tape_symbol;

      unique case (fsm_ff)
         ST_IDLE: begin
            if (accept_req) begin
               unique case (req_operation)
                  OP_APPEND_RULE: begin
                     rsp_strobe_in = 1'b1;
                     if (rule_count_ff >= RULE_CW'(RULE_DEPTH)) begin
                        rsp_full_in = 1'b1;
                     end else begin
                        rule_we       = 1'b1;
                        rule_count_in = rule_count_ff + 1'b1;
                     end
                  end
                  OP_APPEND_TAPE: begin
                     rsp_strobe_in = 1'b1;
                     // A new tape restarts the run before the symbol is appended.
                     if (req_new_tape) begin
                        tape_length_in = '0;
                        head_in        = '0;
                        mstate_in      = start_state_ff;
                        verdict_in     = VERDICT_RUNNING;
                     end
                     if (len_base >= TAPE_CW'(TAPE_DEPTH)) begin
                        rsp_full_in = 1'b1;
                     end else begin
                        tape_we        = 1'b1;
                        tape_length_in = len_base + 1'b1;
                     end
                  end
                  OP_STEP: begin
                     if (verdict_ff != VERDICT_RUNNING) begin
                        rsp_strobe_in = 1'b1;
                     end else if ((tape_length_ff == '0) || (head_ext >= tape_length_ff) ||
                                  (rule_count_ff == '0)) begin
                        verdict_in    = VERDICT_REJECTED;
                        rsp_strobe_in = 1'b1;
                     end else begin
                        // The tape symbol under the head is read at this edge.
                        fsm_in       = ST_SCAN;
                        scan_idx_in  = '0;
                        scan_pend_in = 1'b0;
                     end
                  end
                  default: begin
                     rsp_strobe_in = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (rule_hit) begin
               // The symbol is written even when the head then leaves the tape.
               tape_we       = 1'b1;
               tape_waddr    = head_ff;
               tape_wdata    = rule_rd_ff.write_symbol;
               fsm_in        = ST_IDLE;
               rsp_strobe_in = 1'b1;
               if (left_off || (new_head >= tape_length_ff)) begin
                  verdict_in = VERDICT_REJECTED;
               end else begin
                  head_in   = new_head[TAPE_AW-1:0];
                  mstate_in = rule_rd_ff.target_state;
                  if (rule_rd_ff.target_state == accept_state_ff) begin
                     verdict_in = VERDICT_ACCEPTED;
                  end else if (rule_rd_ff.target_state == reject_state_ff) begin
                     verdict_in = VERDICT_REJECTED;
                  end
               end
            end else if (scan_idx_ff >= rule_count_ff) begin
               // Every loaded rule was checked without a match.
               verdict_in    = VERDICT_REJECTED;
               fsm_in        = ST_IDLE;
               rsp_strobe_in = 1'b1;
            end else begin
               rule_re      = 1'b1;
               scan_idx_in  = scan_idx_ff + 1'b1;
               scan_pend_in = 1'b1;
            end
         end
         default: begin
            fsm_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff         <= ST_IDLE;
         rule_count_ff  <= '0;
         tape_length_ff <= '0;
         mstate_ff      <= '0;
         head_ff        <= '0;
         verdict_ff     <= VERDICT_RUNNING;
         scan_idx_ff    <= '0;
         scan_pend_ff   <= 1'b0;
         rsp_strobe_ff  <= 1'b0;
         rsp_full_ff    <= 1'b0;
      end else begin
         fsm_ff         <= fsm_in;
         rule_count_ff  <= rule_count_in;
         tape_length_ff <= tape_length_in;
         mstate_ff      <= mstate_in;
         head_ff        <= head_in;
         verdict_ff     <= verdict_in;
         scan_idx_ff    <= scan_idx_in;
         scan_pend_ff   <= scan_pend_in;
         rsp_strobe_ff  <= rsp_strobe_in;
         rsp_full_ff    <= rsp_full_in;
      end
   end

   // Configuration register writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_state_ff  <= 7'd0;
         accept_state_ff <= 7'd1;
         reject_state_ff <= 7'd2;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_START_STATE:  start_state_ff  <= csr_write_data;
            CSR_ACCEPT_STATE: accept_state_ff <= csr_write_data;
            CSR_REJECT_STATE: reject_state_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   // Rule table memory, one write and one registered read port.
   always_ff @(posedge clock) begin
      if (rule_we) begin
         rule_mem[rule_waddr] <= rule_wdata;
      end
      if (rule_re) begin
         rule_rd_ff <= rule_mem[rule_raddr];
      end
   end

   // Tape memory; the read port follows the head every cycle.
   always_ff @(posedge clock) begin
      if (tape_we) begin
         tape_mem[tape_waddr] <= tape_wdata;
      end
      tape_rd_ff <= tape_mem[head_ff];
   end

   // Result ports.
   assign head_wide         = 32'(head_ff);
   assign busy              = (fsm_ff != ST_IDLE);
   assign rsp_strobe        = rsp_strobe_ff;
   assign rsp_verdict       = rsp_full_ff ? VERDICT_FULL : verdict_ff;
   assign rsp_machine_state = mstate_ff;
   assign rsp_head_position = head_wide[HEAD_POS_W-1:0];

   // A request other than a step always answers in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_operation != OP_STEP)) |=> rsp_strobe)
      else $error("load request did not strobe a result in the next cycle");

   // No result is shown while a step is still scanning.
   assert property (@(posedge clock) disable iff (reset)
      busy |-> !rsp_strobe)
      else $error("result strobed while the rule scan is running");

   // The rule count never passes the table depth.
   assert property (@(posedge clock) disable iff (reset)
      rule_count_ff <= RULE_CW'(RULE_DEPTH))
      else $error("rule count exceeds the rule table depth");

   // A scan only runs with the head on a nonempty tape.
   assert property (@(posedge clock) disable iff (reset)
      (fsm_ff == ST_SCAN) |-> ((tape_length_ff != '0) && (head_ext < tape_length_ff)))
      else $error("rule scan started with the head off the tape");

   // A step on a halted run leaves verdict, state and head alone.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_operation == OP_STEP) && (verdict_ff != VERDICT_RUNNING))
      |=> ($stable(verdict_ff) && $stable(mstate_ff) && $stable(head_ff)))
      else $error("step after halt changed the machine");

endmodule
